// ----- hdl/bmpq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpq_pkg
// Shared types and operation codes for the bucket priority queue.
// ----------------------------------------------------------------------------
package bmpq_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PEEK   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DEAD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] payload;
    logic [7:0]  priority_req;
    logic [9:0]  node_handle;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  result_node;
    logic [15:0] result_payload;
    logic [7:0]  result_priority;
    logic [1:0]  status;
  } out_item_t;

endpackage
`default_nettype wire

// ----- hdl/bmpq_cmd_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpq_cmd_fifo
// Two-entry command queue between the front end and the list engine.
// ----------------------------------------------------------------------------
module bmpq_cmd_fifo
  import bmpq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_take,
  output in_item_t      out_data
);
  in_item_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_take;
  assign out_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- hdl/bmpq_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpq_engine
// List engine: runs one command over the node and bucket memories.
// ----------------------------------------------------------------------------
module bmpq_engine
  import bmpq_pkg::*;
#(
  parameter int NODE_COUNT      = 1024,
  parameter int PRIORITY_LEVELS = 256,
  parameter int PAYLOAD_BITS    = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_valid,
  output logic          cmd_take,
  input  wire in_item_t cmd,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);
  localparam int NW = $clog2(NODE_COUNT);
  localparam int LW = $clog2(PRIORITY_LEVELS);
  localparam int PW = NW + 1;   // pointer with null code NODE_COUNT
  localparam logic [PW-1:0] NIL = PW'(NODE_COUNT);
  // the reset sweep covers the larger of the two memories it clears
  localparam int IN = (NODE_COUNT > PRIORITY_LEVELS) ? NODE_COUNT : PRIORITY_LEVELS;
  localparam int IW = $clog2(IN);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_EXEC, S_RM2, S_PK_SCAN, S_PK_RD, S_PK_OUT,
    S_CL_SCAN, S_CL_RD, S_CL_STEP, S_OUT
  } state_t;

  // Bucket heads and node memories
  logic [PW-1:0]           bhead_m [PRIORITY_LEVELS];
  logic [PW-1:0]           nnext_m [NODE_COUNT];
  logic [PW-1:0]           nprev_m [NODE_COUNT];
  logic [LW-1:0]           nlevel_m[NODE_COUNT];
  logic [PAYLOAD_BITS-1:0] nitem_m [NODE_COUNT];
  logic                    nlive_m [NODE_COUNT];

  state_t            state_r;
  in_item_t          cmd_r;
  logic [LW-1:0]     lvl_r, hint_r;
  logic [IW-1:0]     init_r;
  logic [PW-1:0]     free_r, nx_r, pv_r, bh_r, fresh_r;
  logic [PW-1:0]     nn_rd_r, np_rd_r;
  logic [LW-1:0]     nl_rd_r;
  logic              live_rd_r;
  logic [PAYLOAD_BITS-1:0] ni_rd_r;
  out_item_t         res_r;
  out_item_t         odata_r;
  logic              ovalid_r;

  logic [LW-1:0] sat_lvl;
  logic [NW-1:0] hidx;
  logic [PW-1:0] alloc_n;
  logic          alloc_ok;
  logic          out_load;
  assign sat_lvl = (cmd.priority_req >= 8'(PRIORITY_LEVELS - 1) &&
                    PRIORITY_LEVELS <= 256) ?
                   LW'(PRIORITY_LEVELS - 1) : LW'(cmd.priority_req);
  assign hidx = NW'(cmd_r.node_handle);

  // take from the free list first, then the never-used nodes
  assign alloc_ok = (free_r != NIL) || (fresh_r != NIL);
  assign alloc_n  = (free_r != NIL) ? free_r : fresh_r;

  assign out_load  = (state_r == S_OUT) && (!ovalid_r || !out_stall);
  assign cmd_take  = (state_r == S_IDLE) && cmd_valid;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      init_r   <= '0;
      free_r   <= NIL;
      fresh_r  <= '0;
      hint_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      // hold the output transaction until it is taken
      if (out_load) begin
        ovalid_r <= 1'b1;
        odata_r  <= res_r;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          // sweep bucket heads to null and live flags to zero
          if (int'(init_r) < PRIORITY_LEVELS) bhead_m[LW'(init_r)] <= NIL;
          if (int'(init_r) < NODE_COUNT) nlive_m[NW'(init_r)] <= 1'b0;
          init_r <= init_r + 1'b1;
          if (init_r == IW'(IN - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            lvl_r   <= sat_lvl;
            res_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          // fetch bucket head, node fields and free-list successor
          bh_r      <= bhead_m[lvl_r];
          nn_rd_r   <= nnext_m[hidx];
          np_rd_r   <= nprev_m[hidx];
          nl_rd_r   <= nlevel_m[hidx];
          live_rd_r <= nlive_m[hidx];
          if (free_r != NIL) nx_r <= nnext_m[NW'(free_r)];
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          case (kind_t'(cmd_r.kind))
            KIND_INSERT: begin
              if (!alloc_ok) begin
                res_r.status <= ST_FULL;
              end else begin
                if (free_r != NIL) free_r <= nx_r;
                else fresh_r <= fresh_r + 1'b1;
                nitem_m[NW'(alloc_n)]  <= cmd_r.payload[PAYLOAD_BITS-1:0];
                nlevel_m[NW'(alloc_n)] <= lvl_r;
                nprev_m[NW'(alloc_n)]  <= NIL;
                nnext_m[NW'(alloc_n)]  <= bh_r;
                nlive_m[NW'(alloc_n)]  <= 1'b1;
                bhead_m[lvl_r]         <= alloc_n;
                if (lvl_r > hint_r) hint_r <= lvl_r;
                pv_r <= alloc_n;
                res_r.result_node <= 10'(alloc_n);
              end
              state_r <= (bh_r != NIL && alloc_ok) ? S_RM2 : S_OUT;
              nx_r <= bh_r;
            end
            KIND_REMOVE: begin
              if (cmd_r.node_handle >= 10'(NODE_COUNT - 1) + 10'd1 &&
                  NODE_COUNT <= 1023 || !live_rd_r) begin
                res_r.status <= ST_DEAD;
                state_r <= S_OUT;
              end else begin
                lvl_r <= nl_rd_r;
                nx_r  <= nn_rd_r;
                pv_r  <= np_rd_r;
                if (np_rd_r != NIL) nnext_m[NW'(np_rd_r)] <= nn_rd_r;
                else bhead_m[nl_rd_r] <= nn_rd_r;
                nnext_m[hidx] <= free_r;
                free_r <= {1'b0, hidx};
                nlive_m[hidx] <= 1'b0;
                state_r <= (nn_rd_r != NIL) ? S_RM2 : S_OUT;
              end
            end
            KIND_PEEK: begin
              lvl_r   <= hint_r;
              state_r <= S_PK_SCAN;
            end
            default: begin
              lvl_r   <= '0;
              state_r <= S_CL_SCAN;
            end
          endcase
        end
        S_RM2: begin
          // fix back link of the successor
          nprev_m[NW'(nx_r)] <= pv_r;
          state_r <= S_OUT;
        end
        S_PK_SCAN: begin
          bh_r    <= bhead_m[lvl_r];
          state_r <= S_PK_RD;
        end
        S_PK_RD: begin
          if (bh_r != NIL) begin
            hint_r  <= lvl_r;
            ni_rd_r <= nitem_m[NW'(bh_r)];
            nl_rd_r <= nlevel_m[NW'(bh_r)];
            state_r <= S_PK_OUT;
          end else if (lvl_r == '0) begin
            res_r.status <= ST_EMPTY;
            state_r <= S_OUT;
          end else begin
            lvl_r   <= lvl_r - 1'b1;
            state_r <= S_PK_SCAN;
          end
        end
        S_PK_OUT: begin
          res_r.result_node     <= 10'(bh_r);
          res_r.result_payload  <= 16'(ni_rd_r);
          res_r.result_priority <= 8'(nl_rd_r);
          state_r <= S_OUT;
        end
        S_CL_SCAN: begin
          bh_r    <= bhead_m[lvl_r];
          state_r <= S_CL_RD;
        end
        S_CL_RD: begin
          if (bh_r != NIL) begin
            nx_r    <= nnext_m[NW'(bh_r)];
            state_r <= S_CL_STEP;
          end else if (lvl_r == LW'(PRIORITY_LEVELS - 1)) begin
            state_r <= S_OUT;
          end else begin
            lvl_r   <= lvl_r + 1'b1;
            state_r <= S_CL_SCAN;
          end
        end
        S_CL_STEP: begin
          // push head onto free list, advance along the bucket
          nnext_m[NW'(bh_r)] <= free_r;
          free_r <= bh_r;
          nlive_m[NW'(bh_r)] <= 1'b0;
          bhead_m[lvl_r] <= nx_r;
          bh_r    <= nx_r;
          state_r <= S_CL_RD;
        end
        S_OUT: begin
          if (!ovalid_r || !out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/bucket_max_priority_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bucket_max_priority_queue
// Bucket priority queue with per-level LIFO lists and a node free list.
// ----------------------------------------------------------------------------
// Usage: commands arrive on in_valid/in_stall/in_data (insert, remove,
// peek, clear) and every command returns exactly one transaction on
// out_valid/out_stall/out_data. A two-entry queue decouples the command
// port from the list engine, so commands are taken while a result waits.
// Insert and remove take an extra step when a successor's back link must be
// fixed; peek scans down from the hint level to the first occupied level, or
// down to level 0 when the queue is empty; clear walks every level and frees
// each queued node. Each step waits on a dependent memory read; one command
// runs at a time.
// After reset the engine sweeps max(NODE_COUNT, PRIORITY_LEVELS) entries,
// one per cycle, nulling bucket heads and clearing live flags; commands
// queue but are not run during that sweep.
// A stalled output holds its transaction; the engine then waits.
// ----------------------------------------------------------------------------
module bucket_max_priority_queue
  import bmpq_pkg::*;
#(
  parameter int NODE_COUNT      = 1024,
  parameter int PRIORITY_LEVELS = 256,
  parameter int PAYLOAD_BITS    = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);
  logic     q_valid, q_take;
  in_item_t q_data;

  bmpq_cmd_fifo u_fifo (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid(q_valid), .out_take(q_take), .out_data(q_data)
  );

  bmpq_engine #(
    .NODE_COUNT(NODE_COUNT), .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_engine (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_data),
    .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire

// ----- verif/tb_bucket_max_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bucket_max_priority_queue
// Self-checking bench: commands go in through the valid/stall port, a local
// model of the bucket lists and free list predicts every result, and each
// returned transaction is compared field by field under random idle patterns.
// ----------------------------------------------------------------------------
module tb_bucket_max_priority_queue;
  import bmpq_pkg::*;

  localparam int NODES  = 1024;
  localparam int LEVELS = 256;
  localparam logic [10:0] NIL = 11'(NODES);

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  bucket_max_priority_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // queue model
  logic [10:0] bucket_head [LEVELS];
  logic [10:0] node_next   [NODES];
  logic [10:0] node_prev   [NODES];
  logic [7:0]  node_level  [NODES];
  logic [15:0] node_item   [NODES];
  logic        node_live   [NODES];
  logic [10:0] free_head;
  logic [10:0] fresh_count;
  logic [7:0]  top_hint;

  out_item_t expected_results[$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void model_reset();
    for (int i = 0; i < LEVELS; i++) bucket_head[i] = NIL;
    for (int i = 0; i < NODES; i++) node_live[i] = 1'b0;
    free_head = NIL;
    fresh_count = '0;
    top_hint = '0;
  endfunction

  function automatic void free_node(input logic [10:0] n);
    node_next[n] = free_head;
    free_head = n;
    node_live[n] = 1'b0;
  endfunction

  function automatic out_item_t apply_command(input in_item_t c);
    out_item_t r;
    logic [10:0] n, nx, pv;
    logic [7:0] lv;
    int i;
    r = '0;
    r.status = ST_OK;
    case (kind_t'(c.kind))
      KIND_INSERT: begin
        lv = c.priority_req;
        n = NIL;
        if (free_head != NIL) begin
          n = free_head;
          free_head = node_next[n];
        end else if (fresh_count < NIL) begin
          n = fresh_count;
          fresh_count++;
        end
        if (n == NIL) begin
          r.status = ST_FULL;
        end else begin
          node_item[n] = c.payload;
          node_level[n] = lv;
          node_live[n] = 1'b1;
          node_prev[n] = NIL;
          node_next[n] = bucket_head[lv];
          if (node_next[n] != NIL) node_prev[node_next[n]] = n;
          bucket_head[lv] = n;
          if (lv > top_hint) top_hint = lv;
          r.result_node = n[9:0];
        end
      end
      KIND_REMOVE: begin
        n = {1'b0, c.node_handle};
        if (!node_live[n]) begin
          r.status = ST_DEAD;
        end else begin
          lv = node_level[n];
          nx = node_next[n];
          pv = node_prev[n];
          if (bucket_head[lv] == n) bucket_head[lv] = nx;
          if (pv != NIL) node_next[pv] = nx;
          if (nx != NIL) node_prev[nx] = pv;
          free_node(n);
        end
      end
      KIND_PEEK: begin
        r.status = ST_EMPTY;
        for (i = int'(top_hint); i >= 0; i--) begin
          if (bucket_head[i] != NIL) begin
            n = bucket_head[i];
            top_hint = 8'(i);
            r.status = ST_OK;
            r.result_node = n[9:0];
            r.result_payload = node_item[n];
            r.result_priority = node_level[n];
            break;
          end
        end
      end
      default: begin
        for (i = 0; i < LEVELS; i++) begin
          while (bucket_head[i] != NIL) begin
            n = bucket_head[i];
            nx = node_next[n];
            free_node(n);
            bucket_head[i] = nx;
          end
        end
      end
    endcase
    return r;
  endfunction

  // hold valid across back-to-back transactions; drop it only while idling
  task automatic send_command(input in_item_t c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(apply_command(c));
  endtask

  function automatic in_item_t make_cmd(input kind_t k, input logic [15:0] p,
                                        input logic [7:0] pr, input logic [9:0] h);
    in_item_t c;
    c.kind = k;
    c.payload = p;
    c.priority_req = pr;
    c.node_handle = h;
    return c;
  endfunction

  // pick a live node most of the time so removes actually unlink
  function automatic logic [9:0] pick_handle();
    int tries;
    logic [9:0] h;
    for (tries = 0; tries < 40; tries++) begin
      h = 10'($urandom_range(int'(fresh_count) > 0 ? int'(fresh_count) - 1 : 0));
      if (node_live[h]) return h;
    end
    return 10'($urandom);
  endfunction

  // result side: random stall, compare on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (out_data.result_node !== e.result_node)
            report_mismatch($sformatf("node %0d exp %0d", out_data.result_node,
                                      e.result_node));
          if (out_data.result_payload !== e.result_payload)
            report_mismatch($sformatf("payload %h exp %h", out_data.result_payload,
                                      e.result_payload));
          if (out_data.result_priority !== e.result_priority)
            report_mismatch($sformatf("priority %0d exp %0d", out_data.result_priority,
                                      e.result_priority));
          if (out_data.status !== e.status)
            report_mismatch($sformatf("status %0d exp %0d", out_data.status, e.status));
        end
      end
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic test_empty_and_dead();
    send_command(make_cmd(KIND_PEEK, 16'h0, 8'h0, 10'd0));
    send_command(make_cmd(KIND_REMOVE, 16'h0, 8'h0, 10'd0));
    send_command(make_cmd(KIND_REMOVE, 16'h0, 8'h0, 10'd1023));
    send_command(make_cmd(KIND_CLEAR, 16'h0, 8'h0, 10'd0));
  endtask

  task automatic test_directed_lists();
    send_command(make_cmd(KIND_INSERT, 16'hFFFF, 8'd255, 10'd0));
    send_command(make_cmd(KIND_INSERT, 16'h0000, 8'd0, 10'd0));
    send_command(make_cmd(KIND_INSERT, 16'hA5A5, 8'd255, 10'd0));
    send_command(make_cmd(KIND_INSERT, 16'h5A5A, 8'd255, 10'd0));
    send_command(make_cmd(KIND_PEEK, 16'h0, 8'h0, 10'd0));
    send_command(make_cmd(KIND_REMOVE, 16'h0, 8'h0, 10'd2));   // middle of list
    send_command(make_cmd(KIND_REMOVE, 16'h0, 8'h0, 10'd3));   // head
    send_command(make_cmd(KIND_REMOVE, 16'h0, 8'h0, 10'd3));   // already freed
    send_command(make_cmd(KIND_PEEK, 16'h0, 8'h0, 10'd0));
    send_command(make_cmd(KIND_REMOVE, 16'h0, 8'h0, 10'd0));
    send_command(make_cmd(KIND_PEEK, 16'h0, 8'h0, 10'd0));     // scan down to level 0
    send_command(make_cmd(KIND_INSERT, 16'h1234, 8'd7, 10'd0)); // reuse free list
    send_command(make_cmd(KIND_INSERT, 16'h4321, 8'd7, 10'd0));
    send_command(make_cmd(KIND_CLEAR, 16'h0, 8'h0, 10'd0));
    send_command(make_cmd(KIND_PEEK, 16'h0, 8'h0, 10'd0));
    send_command(make_cmd(KIND_INSERT, 16'h0001, 8'd128, 10'd0)); // from cleared order
  endtask

  task automatic test_store_full();
    in_item_t c;
    while (fresh_count < NIL || free_head != NIL)
      send_command(make_cmd(KIND_INSERT, 16'($urandom), 8'($urandom), 10'd0));
    send_command(make_cmd(KIND_INSERT, 16'hBEEF, 8'd9, 10'd0));
    send_command(make_cmd(KIND_PEEK, 16'h0, 8'h0, 10'd0));
    send_command(make_cmd(KIND_REMOVE, 16'h0, 8'h0, 10'd1023));
    send_command(make_cmd(KIND_INSERT, 16'hCAFE, 8'd1, 10'd0));
    c = make_cmd(KIND_CLEAR, 16'h0, 8'h0, 10'd0);
    send_command(c);
  endtask

  task automatic test_random(input int count);
    in_item_t c;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      c.payload = 16'($urandom);
      c.priority_req = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
      c.node_handle = 10'($urandom);
      if (sel < 45) c.kind = KIND_INSERT;
      else if (sel < 75) begin
        c.kind = KIND_REMOVE;
        if ($urandom_range(9) != 0) c.node_handle = pick_handle();
      end else if (sel < 98) c.kind = KIND_PEEK;
      else c.kind = KIND_CLEAR;
      send_command(c);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (600) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 26;
    recv_idle_pct = 49;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_dead();
    test_directed_lists();
    test_random(170);
    send_idle_pct = 49;
    recv_idle_pct = 26;
    test_random(170);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(160);
    test_store_full();
    drain();
    if (errors == 0 && expected_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bmpq_pkg.sv
hdl/bmpq_cmd_fifo.sv
hdl/bmpq_engine.sv
hdl/bucket_max_priority_queue.sv
verif/tb_bucket_max_priority_queue.sv
